[hw/rtl/tdctp_pkg.sv]
// Shared types and constants for the time-of-day clock with timer pool.
package tdctp_pkg;

  localparam int TIMERS_DEF    = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MASK_W        = 8;
  localparam int MS_PER_SEC    = 1000;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam logic [26:0] DAY_MS = 27'd86400000;

  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_CLK_START = 4'd1,
    OP_CLK_STOP  = 4'd2,
    OP_CLK_RESET = 4'd3,
    OP_CLK_SET   = 4'd4,
    OP_ALLOC     = 4'd5,
    OP_RELEASE   = 4'd6,
    OP_SET_TMO   = 4'd7,
    OP_T_START   = 4'd8,
    OP_T_STOP    = 4'd9,
    OP_T_RESET   = 4'd10,
    OP_CHECK     = 4'd11,
    OP_NOP       = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_PAUSED  = 2'd1,
    ST_ONGOING = 2'd2,
    ST_TIMEOUT = 2'd3
  } tstat_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_WALK,
    BS_SET_MIN,
    BS_SET_SEC,
    BS_SET_MS,
    BS_FINISH
  } bstate_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  timer_id;
    logic        timer_kind;
    logic [26:0] timeout_ms;
    logic [5:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
    logic [9:0]  set_millis;
  } in_word_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  granted_id;
    logic        timed_out;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis;
    logic [7:0]  expired_mask;
    logic [7:0]  interrupt_mask;
  } out_word_t;

  // Classified command as it sits in the queue.
  typedef struct packed {
    op_t         op;
    logic        id_ok;
    logic [3:0]  id;
    logic        kind;
    logic [26:0] timeout_ms;
    logic        set_ok;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis;
  } cmd_t;

endpackage

[hw/rtl/tdctp_front.sv]
// Front end: accept input words and classify them into queue commands.
module tdctp_front
  import tdctp_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd = '0;
    // fold unused operation codes into a single no-op
    if (in_word.operation > OP_CHECK) begin
      q_cmd.op = OP_NOP;
    end else begin
      q_cmd.op = op_t'(in_word.operation);
    end
    q_cmd.id_ok      = 32'(in_word.timer_id) < TIMERS;
    q_cmd.id         = in_word.timer_id;
    q_cmd.kind       = in_word.timer_kind;
    q_cmd.timeout_ms = in_word.timeout_ms;
    q_cmd.set_ok     = (in_word.set_hours < 6'(HOURS_PER_DAY))
                    && (in_word.set_minutes < 6'(MIN_PER_HOUR))
                    && (in_word.set_seconds < 6'(SEC_PER_MIN))
                    && (in_word.set_millis < 10'(MS_PER_SEC));
    q_cmd.hours      = in_word.set_hours[4:0];
    q_cmd.minutes    = in_word.set_minutes;
    q_cmd.seconds    = in_word.set_seconds;
    q_cmd.millis     = in_word.set_millis;
  end

endmodule

[hw/rtl/tdctp_queue.sv]
// Short command queue between front end and back end.
module tdctp_queue
  import tdctp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/tdctp_back.sv]
// Back end: clock state, timer pool, tick walk and output register.
module tdctp_back
  import tdctp_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int IDXW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  bstate_t         state_r, state_nxt;
  logic            run_r, run_nxt;
  logic [4:0]      hours_r, hours_nxt;
  logic [5:0]      minutes_r, minutes_nxt;
  logic [5:0]      seconds_r, seconds_nxt;
  logic [9:0]      millis_r, millis_nxt;
  logic [26:0]     now_r, now_nxt;
  tstat_t          status_r [TIMERS];
  tstat_t          status_nxt [TIMERS];
  logic            type_r [TIMERS];
  logic            type_nxt [TIMERS];
  logic [26:0]     limit_r [TIMERS];
  logic [26:0]     limit_nxt [TIMERS];
  logic [26:0]     start_r [TIMERS];
  logic [26:0]     start_nxt [TIMERS];
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [7:0]      emask_r, emask_nxt;
  logic [7:0]      imask_r, imask_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  logic            out_free;
  logic            alloc_hit;
  logic [IDXW-1:0] alloc_idx;
  logic [IDXW-1:0] cid;
  logic [27:0]     diff;
  logic [26:0]     elapsed;
  logic            walk_hit;
  logic            load;
  out_word_t       res;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cid       = q_cmd.id[IDXW-1:0];

  // first unused entry
  always_comb begin
    alloc_hit = 1'b0;
    alloc_idx = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (status_r[i] == ST_UNUSED) begin
        alloc_hit = 1'b1;
        alloc_idx = IDXW'(i);
      end
    end
  end

  // elapsed time of the walked entry, wrapped at midnight
  always_comb begin
    diff     = {1'b0, now_r} - {1'b0, start_r[idx_r]};
    elapsed  = diff[27] ? (diff[26:0] + DAY_MS) : diff[26:0];
    walk_hit = (status_r[idx_r] == ST_ONGOING) && (elapsed >= limit_r[idx_r]);
  end

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    hours_nxt     = hours_r;
    minutes_nxt   = minutes_r;
    seconds_nxt   = seconds_r;
    millis_nxt    = millis_r;
    now_nxt       = now_r;
    status_nxt    = status_r;
    type_nxt      = type_r;
    limit_nxt     = limit_r;
    start_nxt     = start_r;
    idx_nxt       = idx_r;
    emask_nxt     = emask_r;
    imask_nxt     = imask_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    res           = '0;

    case (state_r)
      BS_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          case (q_cmd.op)
            OP_TICK: begin
              if (run_r) begin
                // advance one millisecond, then walk the pool
                now_nxt = (now_r == DAY_MS - 1'b1) ? '0 : now_r + 1'b1;
                if (millis_r == 10'(MS_PER_SEC - 1)) begin
                  millis_nxt = '0;
                  if (seconds_r == 6'(SEC_PER_MIN - 1)) begin
                    seconds_nxt = '0;
                    if (minutes_r == 6'(MIN_PER_HOUR - 1)) begin
                      minutes_nxt = '0;
                      hours_nxt   = (hours_r == 5'(HOURS_PER_DAY - 1)) ?
                                    '0 : hours_r + 1'b1;
                    end else begin
                      minutes_nxt = minutes_r + 1'b1;
                    end
                  end else begin
                    seconds_nxt = seconds_r + 1'b1;
                  end
                end else begin
                  millis_nxt = millis_r + 1'b1;
                end
                emask_nxt = '0;
                imask_nxt = '0;
                idx_nxt   = '0;
                load      = 1'b0;
                state_nxt = BS_WALK;
              end
            end
            OP_CLK_START: run_nxt = 1'b1;
            OP_CLK_STOP:  run_nxt = 1'b0;
            OP_CLK_RESET: begin
              run_nxt     = 1'b0;
              hours_nxt   = '0;
              minutes_nxt = '0;
              seconds_nxt = '0;
              millis_nxt  = '0;
              now_nxt     = '0;
            end
            OP_CLK_SET: begin
              run_nxt = 1'b1;
              if (q_cmd.set_ok) begin
                hours_nxt   = q_cmd.hours;
                minutes_nxt = q_cmd.minutes;
                seconds_nxt = q_cmd.seconds;
                millis_nxt  = q_cmd.millis;
                // no timer fires on a set
                emask_nxt   = '0;
                imask_nxt   = '0;
                load        = 1'b0;
                state_nxt   = BS_SET_MIN;
              end
            end
            OP_ALLOC: begin
              if (alloc_hit) begin
                status_nxt[alloc_idx] = ST_PAUSED;
                type_nxt[alloc_idx]   = q_cmd.kind;
                res.granted           = 1'b1;
                res.granted_id        = 4'(alloc_idx);
              end
            end
            OP_RELEASE: begin
              if (q_cmd.id_ok) status_nxt[cid] = ST_UNUSED;
            end
            OP_SET_TMO: begin
              if (q_cmd.id_ok) limit_nxt[cid] = q_cmd.timeout_ms;
            end
            OP_T_START: begin
              if (q_cmd.id_ok) begin
                start_nxt[cid]  = now_r;
                status_nxt[cid] = ST_ONGOING;
              end
            end
            OP_T_STOP: begin
              if (q_cmd.id_ok) status_nxt[cid] = ST_PAUSED;
            end
            OP_T_RESET: begin
              if (q_cmd.id_ok) begin
                start_nxt[cid]  = now_r;
                status_nxt[cid] = ST_PAUSED;
              end
            end
            OP_CHECK: begin
              res.timed_out = q_cmd.id_ok && (status_r[cid] == ST_TIMEOUT);
            end
            default: ;
          endcase
        end
      end
      BS_WALK: begin
        if (walk_hit) begin
          status_nxt[idx_r] = ST_TIMEOUT;
          emask_nxt = emask_r | (8'd1 << idx_r);
          if (type_r[idx_r]) imask_nxt = imask_r | (8'd1 << idx_r);
        end
        if (idx_r == IDXW'(TIMERS - 1)) begin
          state_nxt = BS_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BS_SET_MIN: begin
        now_nxt   = 27'(11'(hours_r) * 11'(MIN_PER_HOUR) + 11'(minutes_r));
        state_nxt = BS_SET_SEC;
      end
      BS_SET_SEC: begin
        now_nxt   = 27'(17'(now_r[10:0]) * 17'(SEC_PER_MIN) + 17'(seconds_r));
        state_nxt = BS_SET_MS;
      end
      BS_SET_MS: begin
        now_nxt   = 27'(now_r[16:0]) * 27'(MS_PER_SEC) + 27'(millis_r);
        state_nxt = BS_FINISH;
      end
      BS_FINISH: begin
        if (out_free) begin
          load               = 1'b1;
          res.expired_mask   = emask_r;
          res.interrupt_mask = imask_r;
          state_nxt          = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase

    if (load) begin
      res.hours     = hours_nxt;
      res.minutes   = minutes_nxt;
      res.seconds   = seconds_nxt;
      res.millis    = millis_nxt;
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      run_r       <= 1'b0;
      hours_r     <= '0;
      minutes_r   <= '0;
      seconds_r   <= '0;
      millis_r    <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TIMERS; i++) begin
        status_r[i] <= ST_UNUSED;
        type_r[i]   <= 1'b0;
        limit_r[i]  <= '0;
        start_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      hours_r     <= hours_nxt;
      minutes_r   <= minutes_nxt;
      seconds_r   <= seconds_nxt;
      millis_r    <= millis_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      type_r      <= type_nxt;
      limit_r     <= limit_nxt;
      start_r     <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    emask_r    <= emask_nxt;
    imask_r    <= imask_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[hw/rtl/time_of_day_clock_with_timer_pool.sv]
// Path: queue, then output register; a running tick walks the pool before its result.
// Throughput: one word per cycle for clock and timer commands unless the output stalls;
//   a running tick holds the back end for its walk, a valid clock set for the set states.
// The tick walk over the pool, one entry per cycle, sets the tick rate.
// Reset (rst_n low, synchronous): clock zeroed and stopped, all timers unused, polling,
//   timeout zero; queue and output register empty.
module time_of_day_clock_with_timer_pool
  import tdctp_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // Front end to queue: classified commands
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;

  // Queue to back end
  logic q_valid;
  logic q_pop;
  cmd_t q_pop_cmd;

  // Classify the incoming word; stall only when the queue is full.
  tdctp_front #(
    .TIMERS(TIMERS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // Hold commands while the back end walks the pool or the output stalls.
  tdctp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_pop_cmd)
  );

  // Execute commands: advance the clock, update timers, drive the result word.
  tdctp_back #(
    .TIMERS(TIMERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[sim/tb_time_of_day_clock_with_timer_pool.sv]
// Self-checking testbench for the time-of-day clock with timer pool.
module tb_time_of_day_clock_with_timer_pool;
  import tdctp_pkg::*;

  localparam int POOL_SIZE = TIMERS_DEF;
  localparam int ITEMS = 2000;
  // A running tick holds the back end while it walks the pool, and a word may wait out
  // long random stall runs on either side; a silence that reaches this limit means a hang.
  localparam int QUIET_LIMIT = 4000;
  localparam int unsigned DAY_LENGTH = DAY_MS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  // Shadow of the block: clock and timer pool as the design should hold them.
  logic [4:0] tod_hours;
  logic [5:0] tod_minutes;
  logic [5:0] tod_seconds;
  logic [9:0] tod_millis;
  logic tod_running;
  tstat_t pool_status[POOL_SIZE];
  logic pool_kind[POOL_SIZE];
  logic [26:0] pool_limit[POOL_SIZE];
  logic [26:0] pool_start[POOL_SIZE];

  out_word_t expected_words[$];
  out_word_t last_prediction;
  int items_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  time_of_day_clock_with_timer_pool #(
    .TIMERS(POOL_SIZE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #10 clk = ~clk;

  // Milliseconds since midnight of the shadow clock.
  function automatic int unsigned millis_of_day();
    int unsigned t;
    t = tod_hours;
    t = t * MIN_PER_HOUR + tod_minutes;
    t = t * SEC_PER_MIN + tod_seconds;
    return t * MS_PER_SEC + tod_millis;
  endfunction

  // Advance the shadow by one accepted word and work out the result word it must give.
  task automatic predict_word(input in_word_t w, output out_word_t r);
    int unsigned now;
    int unsigned elapsed;
    logic id_ok;
    r = '0;
    id_ok = int'(w.timer_id) < POOL_SIZE;
    case (op_t'(w.operation))
      OP_TICK: begin
        // A stopped clock ignores the tick altogether; no timer is looked at.
        if (tod_running) begin
          if (tod_millis == MS_PER_SEC - 1) begin
            tod_millis = '0;
            if (tod_seconds == SEC_PER_MIN - 1) begin
              tod_seconds = '0;
              if (tod_minutes == MIN_PER_HOUR - 1) begin
                tod_minutes = '0;
                tod_hours = (tod_hours == HOURS_PER_DAY - 1) ? 5'd0 : tod_hours + 5'd1;
              end else begin
                tod_minutes++;
              end
            end else begin
              tod_seconds++;
            end
          end else begin
            tod_millis++;
          end
          now = millis_of_day();
          for (int i = 0; i < POOL_SIZE; i++) begin
            if (pool_status[i] == ST_ONGOING) begin
              // Elapsed time wraps at midnight, so a timeout of a day or more never fires.
              elapsed = (now + DAY_LENGTH - pool_start[i]) % DAY_LENGTH;
              if (elapsed >= pool_limit[i]) begin
                pool_status[i] = ST_TIMEOUT;
                if (i < MASK_W) begin
                  r.expired_mask[i] = 1'b1;
                  r.interrupt_mask[i] = pool_kind[i];
                end
              end
            end
          end
        end
      end
      OP_CLK_START: tod_running = 1'b1;
      OP_CLK_STOP: tod_running = 1'b0;
      OP_CLK_RESET: begin
        tod_running = 1'b0;
        tod_hours = '0;
        tod_minutes = '0;
        tod_seconds = '0;
        tod_millis = '0;
      end
      OP_CLK_SET: begin
        // An out-of-range set keeps the time but still starts the clock.
        if (w.set_hours < HOURS_PER_DAY && w.set_minutes < MIN_PER_HOUR &&
            w.set_seconds < SEC_PER_MIN && w.set_millis < MS_PER_SEC) begin
          tod_hours = w.set_hours[4:0];
          tod_minutes = w.set_minutes;
          tod_seconds = w.set_seconds;
          tod_millis = w.set_millis;
        end
        tod_running = 1'b1;
      end
      OP_ALLOC: begin
        // First unused entry wins; timeout and start time are left as they were.
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (!r.granted && pool_status[i] == ST_UNUSED) begin
            pool_status[i] = ST_PAUSED;
            pool_kind[i] = w.timer_kind;
            r.granted = 1'b1;
            r.granted_id = 4'(i);
          end
        end
      end
      OP_RELEASE: if (id_ok) pool_status[w.timer_id] = ST_UNUSED;
      OP_SET_TMO: if (id_ok) pool_limit[w.timer_id] = w.timeout_ms;
      OP_T_START: begin
        if (id_ok) begin
          pool_start[w.timer_id] = 27'(millis_of_day());
          pool_status[w.timer_id] = ST_ONGOING;
        end
      end
      OP_T_STOP: if (id_ok) pool_status[w.timer_id] = ST_PAUSED;
      OP_T_RESET: begin
        if (id_ok) begin
          pool_start[w.timer_id] = 27'(millis_of_day());
          pool_status[w.timer_id] = ST_PAUSED;
        end
      end
      OP_CHECK: if (id_ok) r.timed_out = (pool_status[w.timer_id] == ST_TIMEOUT);
      default: ;
    endcase
    r.hours = tod_hours;
    r.minutes = tod_minutes;
    r.seconds = tod_seconds;
    r.millis = tod_millis;
  endtask

  // Fill every field at random, then pin the operation and the entry.
  function automatic in_word_t random_word(logic [3:0] op, logic [3:0] id);
    in_word_t w;
    w = in_word_t'({$urandom, $urandom});
    w.operation = op;
    w.timer_id = id;
    return w;
  endfunction

  function automatic in_word_t clock_set_word(int h, int m, int s, int ms);
    in_word_t w;
    w = random_word(OP_CLK_SET, 4'($urandom));
    w.set_hours = 6'(h);
    w.set_minutes = 6'(m);
    w.set_seconds = 6'(s);
    w.set_millis = 10'(ms);
    return w;
  endfunction

  // Offer one word, hold it until accepted, then log what it must produce.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w, last_prediction);
    expected_words.push_back(last_prediction);
    items_sent++;
  endtask

  // Drop a stall on the result side at the rate of the current phase.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    out_word_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected result word: expected none, got %h", $time, out_word);
        mismatches++;
      end else begin
        exp = expected_words.pop_front();
        check_field("granted", exp.granted, out_word.granted);
        check_field("granted_id", exp.granted_id, out_word.granted_id);
        check_field("timed_out", exp.timed_out, out_word.timed_out);
        check_field("hours", exp.hours, out_word.hours);
        check_field("minutes", exp.minutes, out_word.minutes);
        check_field("seconds", exp.seconds, out_word.seconds);
        check_field("millis", exp.millis, out_word.millis);
        check_field("expired_mask", exp.expired_mask, out_word.expired_mask);
        check_field("interrupt_mask", exp.interrupt_mask, out_word.interrupt_mask);
      end
    end
  end

  // Count cycles in which no word moves on either side; a long silence is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset state, and a tick that a stopped clock must ignore.
  task automatic test_reset_state();
    send_word(random_word(OP_CHECK, 4'd0));
    send_word(random_word(OP_TICK, 4'd0));
  endtask

  // Clock control: invalid sets, stop, midnight wrap, reset and unused codes.
  task automatic test_clock_control();
    send_word(clock_set_word(63, 0, 0, 0));
    send_word(random_word(OP_TICK, 4'd1));
    send_word(random_word(OP_CLK_STOP, 4'd2));
    send_word(random_word(OP_TICK, 4'd3));
    send_word(clock_set_word(23, 59, 59, 999));
    send_word(random_word(OP_TICK, 4'd4));
    send_word(random_word(OP_CLK_RESET, 4'd5));
    send_word(random_word(4'd15, 4'd6));
    send_word(clock_set_word(12, 30, 30, 1023));
  endtask

  // Fill the pool, get refused, then run short and unreachable timeouts.
  task automatic test_timer_pool();
    in_word_t w;
    for (int k = 0; k < POOL_SIZE; k++) begin
      w = random_word(OP_ALLOC, 4'($urandom));
      w.timer_kind = k[0];
      send_word(w);
    end
    send_word(random_word(OP_ALLOC, 4'd0));
    send_word(random_word(OP_RELEASE, 4'd15));
    w = random_word(OP_SET_TMO, 4'd3);
    w.timeout_ms = 27'h7FFFFFF;
    send_word(w);
    w = random_word(OP_SET_TMO, 4'd1);
    w.timeout_ms = 27'd1;
    send_word(w);
    send_word(random_word(OP_T_START, 4'd0));
    send_word(random_word(OP_T_START, 4'd1));
    send_word(random_word(OP_T_START, 4'd3));
    send_word(random_word(OP_TICK, 4'd0));
    send_word(random_word(OP_CHECK, 4'd1));
    send_word(random_word(OP_CHECK, 4'd12));
    // Capture the time with the clock stopped.
    send_word(random_word(OP_CLK_STOP, 4'd0));
    send_word(random_word(OP_T_RESET, 4'd2));
    send_word(random_word(OP_T_START, 4'd5));
  endtask

  // One well-formed timer life: allocate, arm, start, tick it down, check, tidy up.
  task automatic run_timer_story();
    in_word_t w;
    logic [3:0] id;
    if (!tod_running || $urandom_range(9) == 0) begin
      // Now and then park the clock just short of midnight to exercise the wrap.
      if ($urandom_range(2) == 0) send_word(clock_set_word(23, 59, 59, $urandom_range(960, 999)));
      else send_word(random_word(OP_CLK_START, 4'($urandom)));
    end
    w = random_word(OP_ALLOC, 4'($urandom));
    send_word(w);
    id = last_prediction.granted ? last_prediction.granted_id : 4'($urandom_range(POOL_SIZE - 1));
    w = random_word(OP_SET_TMO, id);
    if ($urandom_range(9) != 0) w.timeout_ms = 27'($urandom_range(40));
    send_word(w);
    send_word(random_word(OP_T_START, id));
    repeat ($urandom_range(45)) begin
      if ($urandom_range(11) == 0) begin
        send_word(random_word(OP_CHECK, 4'($urandom_range(POOL_SIZE - 1))));
      end
      send_word(random_word(OP_TICK, 4'($urandom)));
    end
    send_word(random_word(OP_CHECK, id));
    case ($urandom_range(3))
      0: send_word(random_word(OP_T_STOP, id));
      1: send_word(random_word(OP_T_RESET, id));
      default: ;
    endcase
    if ($urandom_range(9) < 6) send_word(random_word(OP_RELEASE, id));
  endtask

  // Mostly timer stories, the rest bursts of arbitrary words.
  task automatic run_random_items(int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(99) < 70) begin
        run_timer_story();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_word(random_word(4'($urandom_range(15)), 4'($urandom_range(15))));
        end
      end
    end
  endtask

  // Random traffic under each idling pattern in turn.
  task automatic test_random_traffic();
    int gaps[4] = '{0, 47, 0, 22};
    int stalls[4] = '{0, 0, 47, 22};
    for (int p = 0; p < 4; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      run_random_items(ITEMS / 4);
    end
  endtask

  initial begin
    tod_hours = '0;
    tod_minutes = '0;
    tod_seconds = '0;
    tod_millis = '0;
    tod_running = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_status[i] = ST_UNUSED;
      pool_kind[i] = 1'b0;
      pool_limit[i] = '0;
      pool_start[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_clock_control();
    test_timer_pool();
    test_random_traffic();
    in_valid <= 1'b0;
    // Drain, then give the back end a tick's worth of cycles to show any stray word.
    while (expected_words.size() != 0) @(posedge clk);
    stall_pct = 0;
    repeat (POOL_SIZE + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
